/* rtl/tlb_pkg.sv */
`default_nettype none

package tlb_pkg;

   // Default line length in characters.
   localparam int LINE_LENGTH = 32;

   // Operation codes.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_CHAR   = 2'd1;
   localparam logic [1:0] OP_NUMBER = 2'd2;
   localparam logic [1:0] OP_INIT   = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_INIT = 2'd1;
   localparam logic [1:0] ST_INVALID  = 2'd2;

   // Characters.
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] MARK_CHAR  = 8'h3F;
   localparam logic [7:0] MINUS_CHAR = 8'h2D;
   localparam logic [7:0] ZERO_CHAR  = 8'h30;

   // A 16-bit magnitude has at most five decimal digits.
   localparam int MAX_DIGITS = 5;

   // Reciprocal of ten: (x * 0xCCCD) >> 19 equals x / 10 for any 16-bit x.
   localparam logic [15:0] RECIP_TEN = 16'hCCCD;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      logic [1:0]         op;
      logic               tx_ready;
      logic [7:0]         char_code;
      logic [5:0]         position;
      logic signed [15:0] number;
      logic [5:0]         field_width;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       tx_valid;
      logic [7:0] tx_byte;
   } rsp_type;

   // Result of a decimal conversion, least significant digit first.
   typedef struct packed {
      logic                         done;
      logic [2:0]                   count;
      logic [MAX_DIGITS-1:0][3:0]   digits;
   } dig_res_type;

endpackage

`default_nettype wire

/* rtl/tlb_digit_unit.sv */
`default_nettype none

module tlb_digit_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [15:0]         mag,
   output tlb_pkg::dig_res_type     result
);

   logic                                     busy_ff;
   logic                                     done_ff;
   logic [15:0]                              mag_ff;
   logic [2:0]                               count_ff;
   logic [tlb_pkg::MAX_DIGITS-1:0][3:0]      digits_ff;

   logic [31:0] prod;
   logic [15:0] mag_in;
   logic [18:0] ten_q;
   logic [3:0]  rem;

   // One digit per cycle: quotient by reciprocal multiply, remainder by subtract.
   always_comb begin
      prod   = mag_ff * tlb_pkg::RECIP_TEN;
      mag_in = 16'(prod >> tlb_pkg::RECIP_SHIFT);
      ten_q  = {mag_in, 3'b000} + {2'b00, mag_in, 1'b0};
      rem    = 4'(mag_ff - ten_q[15:0]);
   end

   // Conversion sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            mag_ff   <= mag;
            count_ff <= 3'd0;
         end else if (busy_ff) begin
            digits_ff[count_ff] <= rem;
            count_ff            <= count_ff + 3'd1;
            mag_ff              <= mag_in;
            if (mag_in == 16'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign result.done   = done_ff;
   assign result.count  = count_ff;
   assign result.digits = digits_ff;

endmodule

`default_nettype wire

/* rtl/tlb_line_ram.sv */
`default_nettype none

module tlb_line_ram #(
   parameter int LINE_LENGTH = tlb_pkg::LINE_LENGTH,
   localparam int AW = $clog2(LINE_LENGTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [7:0]    rd_data
);

   logic [7:0] mem [LINE_LENGTH];
   logic [7:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/text_line_buffer_display_refresh.sv */
`default_nettype none

// Flow: a tick that sends reads the line memory (S_READ) before S_RESP; a character
// write, a busy tick, a repeated init or any rejected op goes straight to S_RESP; a
// first init fills the line (S_FILL) and a number write converts (S_CONV) and writes
// its field (S_WRITE) first. Throughput: one item at a time; the next transfer is taken
// the cycle after the output register loads, which waits while the output is stalled.
// Reset clears the state, refresh and fill indexes and ready flag; init fills the line.
module text_line_buffer_display_refresh #(
   parameter int LINE_LENGTH = tlb_pkg::LINE_LENGTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire tlb_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      tlb_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(LINE_LENGTH);
   localparam logic [6:0]    LenC  = 7'(LINE_LENGTH);
   localparam logic [AW-1:0] LastC = AW'(LINE_LENGTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_CONV,
      S_WRITE,
      S_READ,
      S_RESP
   } state_type;

   state_type         state_ff;
   logic              ready_ff;
   logic [AW-1:0]     refresh_ff;
   logic [AW-1:0]     fill_ff;
   logic [AW-1:0]     addr_ff;
   logic [5:0]        k_ff;
   logic [5:0]        width_ff;
   logic [5:0]        pad_ff;
   logic [2:0]        len_ff;
   logic              neg_ff;
   logic              over_ff;
   tlb_pkg::rsp_type  res_ff;
   logic              rsp_valid_ff;
   tlb_pkg::rsp_type  rsp_data_ff;

   logic              req_xfer;
   logic              rsp_free;
   logic              neg;
   logic [15:0]       mag;
   logic [6:0]        field_end;
   logic              char_ok;
   logic              num_ok;
   logic              conv_start;
   tlb_pkg::dig_res_type dig;
   logic [2:0]        len_calc;
   logic [5:0]        len_ext;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [7:0]        mem_wdata;
   logic [7:0]        mem_rdata;

   logic              is_pad;
   logic              is_mark;
   logic [2:0]        j;
   logic [2:0]        di;
   logic [2:0]        di_safe;
   logic [7:0]        wr_char;

   assign req_xfer = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Request checks and magnitude of the number.
   always_comb begin
      neg       = req_data.number[15];
      mag       = neg ? 16'(~req_data.number + 16'sd1) : 16'(req_data.number);
      field_end = {1'b0, req_data.position} + {1'b0, req_data.field_width};
      char_ok   = ({1'b0, req_data.position} < LenC) && (req_data.char_code != 8'd0);
      num_ok    = (req_data.field_width != 6'd0) && (field_end <= LenC);
      conv_start = req_xfer && ready_ff && (req_data.op == tlb_pkg::OP_NUMBER) && num_ok;
      len_calc  = dig.count + {2'b00, neg_ff};
      len_ext   = {3'b000, len_calc};
   end

   // Character for the current field offset during a number write.
   always_comb begin
      is_pad  = k_ff < pad_ff;
      is_mark = over_ff && (k_ff == width_ff - 6'd1);
      j       = 3'(k_ff - pad_ff);
      di      = len_ff - 3'd1 - j;
      di_safe = (di < 3'(tlb_pkg::MAX_DIGITS)) ? di : 3'd0;
      if (is_pad) begin
         wr_char = tlb_pkg::SPACE_CHAR;
      end else if (is_mark) begin
         wr_char = tlb_pkg::MARK_CHAR;
      end else if (neg_ff && (j == 3'd0)) begin
         wr_char = tlb_pkg::MINUS_CHAR;
      end else begin
         wr_char = tlb_pkg::ZERO_CHAR + {4'b0000, dig.digits[di_safe]};
      end
   end

   // Line memory write port.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = wr_char;
      case (state_ff)
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_ff;
            mem_wdata = tlb_pkg::SPACE_CHAR;
         end
         S_WRITE: begin
            mem_we = 1'b1;
         end
         S_IDLE: begin
            mem_we    = req_xfer && ready_ff && (req_data.op == tlb_pkg::OP_CHAR) && char_ok;
            mem_waddr = AW'(req_data.position);
            mem_wdata = req_data.char_code;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   tlb_line_ram #(
      .LINE_LENGTH(LINE_LENGTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (refresh_ff),
      .rd_data (mem_rdata)
   );

   tlb_digit_unit u_digits (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .mag    (mag),
      .result (dig)
   );

   // Sequencer with result hold and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         refresh_ff   <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  res_ff   <= '{status: tlb_pkg::ST_OK, tx_valid: 1'b0, tx_byte: 8'd0};
                  state_ff <= S_RESP;
                  if (req_data.op == tlb_pkg::OP_INIT) begin
                     if (!ready_ff) begin
                        fill_ff  <= '0;
                        state_ff <= S_FILL;
                     end
                  end else if (!ready_ff) begin
                     res_ff.status <= tlb_pkg::ST_NOT_INIT;
                  end else begin
                     case (req_data.op)
                        tlb_pkg::OP_TICK: begin
                           if (req_data.tx_ready) begin
                              state_ff <= S_READ;
                           end
                        end
                        tlb_pkg::OP_CHAR: begin
                           if (!char_ok) begin
                              res_ff.status <= tlb_pkg::ST_INVALID;
                           end
                        end
                        tlb_pkg::OP_NUMBER: begin
                           if (!num_ok) begin
                              res_ff.status <= tlb_pkg::ST_INVALID;
                           end else begin
                              neg_ff   <= neg;
                              width_ff <= req_data.field_width;
                              addr_ff  <= AW'(req_data.position);
                              k_ff     <= 6'd0;
                              state_ff <= S_CONV;
                           end
                        end
                        default: begin
                           state_ff <= S_RESP;
                        end
                     endcase
                  end
               end
            end
            S_FILL: begin
               fill_ff <= fill_ff + AW'(1);
               if (fill_ff == LastC) begin
                  ready_ff <= 1'b1;
                  state_ff <= S_RESP;
               end
            end
            S_CONV: begin
               if (dig.done) begin
                  len_ff   <= len_calc;
                  over_ff  <= len_ext > width_ff;
                  pad_ff   <= (width_ff > len_ext) ? (width_ff - len_ext) : 6'd0;
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               k_ff    <= k_ff + 6'd1;
               addr_ff <= addr_ff + AW'(1);
               if (k_ff == width_ff - 6'd1) begin
                  state_ff <= S_RESP;
               end
            end
            S_READ: begin
               res_ff.tx_valid <= 1'b1;
               res_ff.tx_byte  <= mem_rdata;
               refresh_ff      <= (refresh_ff == LastC) ? '0 : refresh_ff + AW'(1);
               state_ff        <= S_RESP;
            end
            S_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The ready flag, once set, is never cleared outside reset.
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      ready_ff |=> ready_ff)
      else $error("ready flag cleared");

   // The line changes in idle only on an accepted character write.
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == S_IDLE) |-> (req_xfer && req_data.op == tlb_pkg::OP_CHAR))
      else $error("line written without a transfer");

   // A sent character always comes with an OK status.
   a_tx_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.tx_valid) |-> (rsp_data.status == tlb_pkg::ST_OK))
      else $error("character sent with error status");

   // The result register is never overwritten while a result waits.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_RESP))
      else $error("result lost");

   // Writing starts only once the number is converted.
   a_write_after_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && $past(state_ff) == S_CONV) |-> $past(dig.done))
      else $error("write before conversion finished");

endmodule

`default_nettype wire

/* dv/text_line_buffer_display_refresh_checker.sv */
`timescale 1ns / 1ps

module text_line_buffer_display_refresh_checker
   import tlb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   // Local copy of the display line and its refresh state.
   logic [7:0] line_chars [LINE_LENGTH];
   logic [4:0] scan_index;
   logic       line_ready;

   // Outputs predicted for accepted requests, oldest first.
   rsp_type    pending_outputs [$];
   int         errors = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Applies one request to the local line copy and returns the output it causes.
   function automatic rsp_type apply_request(input req_type item);
      rsp_type    result;
      logic [7:0] text [8];
      logic [7:0] digits_rev [8];
      int         value;
      int         magnitude;
      int         ndig;
      int         len;
      int         count;
      int         at;
      int         pos;
      int         wid;
      result        = '0;
      result.status = ST_OK;
      pos           = item.position;
      wid           = item.field_width;
      if (item.op == OP_INIT) begin
         // A second init leaves the line alone.
         if (!line_ready) begin
            for (int i = 0; i < LINE_LENGTH; i++) line_chars[i] = SPACE_CHAR;
            line_ready = 1'b1;
         end
      end else if (!line_ready) begin
         result.status = ST_NOT_INIT;
      end else if (item.op == OP_TICK) begin
         // A busy transmitter holds the refresh index where it is.
         if (item.tx_ready) begin
            result.tx_valid = 1'b1;
            result.tx_byte  = line_chars[scan_index];
            scan_index      = scan_index + 5'd1;
         end
      end else if (item.op == OP_CHAR) begin
         if (pos >= LINE_LENGTH || item.char_code == 8'd0) begin
            result.status = ST_INVALID;
         end else begin
            line_chars[pos] = item.char_code;
         end
      end else begin
         if (wid == 0 || pos + wid > LINE_LENGTH) begin
            result.status = ST_INVALID;
         end else begin
            // Build the decimal text, sign first.
            value     = item.number;
            magnitude = (value < 0) ? -value : value;
            ndig      = 0;
            do begin
               digits_rev[ndig] = ZERO_CHAR + 8'(magnitude % 10);
               magnitude        = magnitude / 10;
               ndig++;
            end while (magnitude != 0);
            len = 0;
            if (value < 0) begin
               text[0] = MINUS_CHAR;
               len     = 1;
            end
            for (int i = ndig - 1; i >= 0; i--) begin
               text[len] = digits_rev[i];
               len++;
            end
            // Too long: keep the leading characters and mark the last one.
            // Too short: pad the front of the field with spaces.
            count = len;
            at    = pos;
            if (len > wid) begin
               text[wid - 1] = MARK_CHAR;
               count         = wid;
            end else begin
               for (int i = 0; i < wid - len; i++) line_chars[pos + i] = SPACE_CHAR;
               at = pos + wid - len;
            end
            for (int i = 0; i < count; i++) line_chars[at + i] = text[i];
         end
      end
      return result;
   endfunction

   // Predict on every request transfer and compare on every result transfer.
   always @(posedge clock) begin
      rsp_type wanted;
      if (reset) begin
         for (int i = 0; i < LINE_LENGTH; i++) line_chars[i] = SPACE_CHAR;
         scan_index = '0;
         line_ready = 1'b0;
         pending_outputs.delete();
      end else begin
         if (req_valid && req_ready) begin
            pending_outputs.push_back(apply_request(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               $display("%0t: result with nothing expected, actual %p", $time, rsp_data);
               errors++;
            end else begin
               wanted = pending_outputs.pop_front();
               if (rsp_data.status !== wanted.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, wanted.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.tx_valid !== wanted.tx_valid) begin
                  $display("%0t: tx_valid expected %0d, actual %0d",
                           $time, wanted.tx_valid, rsp_data.tx_valid);
                  errors++;
               end
               if (rsp_data.tx_byte !== wanted.tx_byte) begin
                  $display("%0t: tx_byte expected 0x%02h, actual 0x%02h",
                           $time, wanted.tx_byte, rsp_data.tx_byte);
                  errors++;
               end
            end
         end
      end
      pending_count <= pending_outputs.size();
      fail_count    <= errors;
   end

endmodule

/* dv/text_line_buffer_display_refresh_tb.sv */
`timescale 1ns / 1ps

module text_line_buffer_display_refresh_tb;
   import tlb_pkg::*;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int ITEMS_PER_PHASE  = 500;
   localparam int DRAIN_CYCLES     = 60;
   localparam int LONG_HOLD_CYCLES = 400;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_ready;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      fail_count;
   int      pending_count;
   int      sender_idle_pct   = 0;
   int      receiver_idle_pct = 0;
   logic    long_hold_go      = 1'b0;
   int      cycle_count       = 0;

   text_line_buffer_display_refresh DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   text_line_buffer_display_refresh_checker line_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off that fills the block.
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_go && !hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   function automatic req_type make_item(input logic [1:0] op, input logic tx_ready,
                                         input logic [7:0] ch, input logic [5:0] pos,
                                         input logic signed [15:0] num,
                                         input logic [5:0] wid);
      req_type item;
      item.op          = op;
      item.tx_ready    = tx_ready;
      item.char_code   = ch;
      item.position    = pos;
      item.number      = num;
      item.field_width = wid;
      return item;
   endfunction

   // Mostly well-formed writes and ticks, with some raw noise mixed in.
   function automatic req_type random_item();
      req_type item;
      int      pick;
      int      wid;
      pick = $urandom_range(99);
      if (pick < 40) item.op = OP_TICK;
      else if (pick < 60) item.op = OP_CHAR;
      else if (pick < 92) item.op = OP_NUMBER;
      else item.op = OP_INIT;
      item.tx_ready  = ($urandom_range(99) < 80);
      item.char_code = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(255));
      if ($urandom_range(1) == 0) item.number = 16'($urandom_range(65535));
      else item.number = 16'($urandom_range(200) - 100);
      pick = $urandom_range(9);
      if (pick < 8) begin
         // Short fields keep number writes cheap; some range up to the whole line.
         wid              = (pick < 6) ? $urandom_range(8, 1) : $urandom_range(LINE_LENGTH, 1);
         item.field_width = 6'(wid);
         item.position    = 6'($urandom_range(LINE_LENGTH - wid));
      end else begin
         item.field_width = 6'($urandom_range(63));
         item.position    = 6'($urandom_range(63));
      end
      if ($urandom_range(19) == 0) item = req_type'({$urandom, $urandom});
      return item;
   endfunction

   // Offers one item, possibly after some idle cycles, and waits for its transfer.
   task automatic send_item(input req_type item);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      req_type directed [$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Ops before init, repeated init, busy transmitter.
      directed.push_back(make_item(OP_TICK, 1'b1, 8'h00, 6'd0, 16'sd0, 6'd0));
      directed.push_back(make_item(OP_CHAR, 1'b1, 8'h41, 6'd0, 16'sd0, 6'd0));
      directed.push_back(make_item(OP_NUMBER, 1'b1, 8'h00, 6'd0, 16'sd123, 6'd4));
      directed.push_back(make_item(OP_INIT, 1'b0, 8'h00, 6'd0, 16'sd0, 6'd0));
      directed.push_back(make_item(OP_INIT, 1'b1, 8'hFF, 6'd63, -16'sd1, 6'd63));
      directed.push_back(make_item(OP_TICK, 1'b0, 8'h00, 6'd0, 16'sd0, 6'd0));
      // A full-line number write, then character writes, good and rejected.
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd0, -16'sd1, 6'd32));
      directed.push_back(make_item(OP_CHAR, 1'b0, 8'hFF, 6'd31, 16'sd0, 6'd0));
      directed.push_back(make_item(OP_CHAR, 1'b0, 8'h41, 6'd0, 16'sd0, 6'd0));
      directed.push_back(make_item(OP_CHAR, 1'b0, 8'h00, 6'd5, 16'sd0, 6'd0));
      directed.push_back(make_item(OP_CHAR, 1'b0, 8'h42, 6'd32, 16'sd0, 6'd0));
      directed.push_back(make_item(OP_CHAR, 1'b0, 8'h42, 6'd63, 16'sd0, 6'd0));
      // Number writes: exact fit, padded, truncated, rejected.
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd1, -16'sd32768, 6'd6));
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd8, 16'sd32767, 6'd8));
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd16, 16'sd0, 6'd1));
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd20, -16'sd32768, 6'd3));
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd24, 16'sd12345, 6'd1));
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd2, 16'sd7, 6'd0));
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd1, 16'sd7, 6'd32));
      directed.push_back(make_item(OP_NUMBER, 1'b0, 8'h00, 6'd63, 16'sd7, 6'd63));
      repeat (5) directed.push_back(make_item(OP_TICK, 1'b1, 8'h00, 6'd0, 16'sd0, 6'd0));
      foreach (directed[i]) send_item(directed[i]);
      wait_for_results();

      // Random phases: sender mostly busy, then receiver mostly busy, then no idling
      // apart from one long hold-off on the result side.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   <= (phase == 0) ? 17 : (phase == 1) ? 74 : 0;
         receiver_idle_pct <= (phase == 0) ? 74 : (phase == 1) ? 17 : 0;
         if (phase == 2) long_hold_go <= 1'b1;
         repeat (ITEMS_PER_PHASE) send_item(random_item());
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/tlb_pkg.sv
rtl/tlb_digit_unit.sv
rtl/tlb_line_ram.sv
rtl/text_line_buffer_display_refresh.sv
dv/text_line_buffer_display_refresh_checker.sv
dv/text_line_buffer_display_refresh_tb.sv
